FILE: design/assert_macros.svh
// Assertion helpers used by the keypad event queue unit.
// Every check is clocked on the rising edge of clk and is switched off
// while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define KPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define KPQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/kpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad event queue package
// Shared widths and the record types passed to the event step unit.
// ----------------------------------------------------------------------------
package kpq_pkg;

    localparam int MASK_W      = 32;  // width of the key masks on the ports
    localparam int KEY_W       = 5;   // width of a key number on the ports
    localparam int KEY_ID_W    = 6;   // width of the key number of a request
    localparam int RCOUNT_W    = 8;   // width of the repeat press count
    localparam int TIMER_W     = 4;   // width of the repeat timer
    localparam int LEVEL_W     = 4;   // width of the reported counts
    localparam int THRESH_W    = 4;   // width of the threshold register

    localparam logic [TIMER_W-1:0]  THRESH_RESET = 4'd4;
    localparam logic [RCOUNT_W-1:0] RCOUNT_MAX   = 8'd255;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 4'd15;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // One queued event together with the tick context it is judged against.
    typedef struct packed {
        logic                kind;
        logic [KEY_W-1:0]    key;
        logic [MASK_W-1:0]   change;
        logic [MASK_W-1:0]   keys;
        logic                tracked;
        logic [KEY_W-1:0]    rkey;
        logic [RCOUNT_W-1:0] rcount;
    } step_in_t;

    // Outcome of one event step.
    typedef struct packed {
        logic                stop;
        logic                press;
        logic [MASK_W-1:0]   change;
        logic                tracked;
        logic [KEY_W-1:0]    rkey;
        logic [RCOUNT_W-1:0] rcount;
    } step_out_t;

endpackage

FILE: design/keypad_event_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad event queue unit
// Ring queue of key press and release events feeding a held-down key mask,
// with multi-click repeat tracking. Add requests store events; update ticks
// drain them through a shared event step unit.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | in_valid / in_ready  | req_type, key_id, pressed
// output   | out_valid / out_ready| accepted ... queue_level (one item each)
// config   | cfg_we               | cfg_data (multi-click threshold)
//
// An add request passes through the add and finish states, an update tick
// through the age, drain, commit and finish states; the event step unit
// judges one queued event per cycle in the drain state, fed by the event
// RAM read port. A full queue holds 15 events. Reset is asynchronous and
// active low; the event RAM is not cleared. A new item is taken while an
// earlier result still waits; only the final state holds until it is taken.
// ----------------------------------------------------------------------------
module keypad_event_queue_unit #(
    parameter int NUM_KEYS    = 32,
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_ID_BITS = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [kpq_pkg::KEY_ID_W-1:0]     key_id,
    input  logic                             pressed,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             accepted,
    output logic                             overflowed,
    output logic [kpq_pkg::MASK_W-1:0]       keys_down,
    output logic [kpq_pkg::MASK_W-1:0]       keys_before,
    output logic [kpq_pkg::MASK_W-1:0]       newly_pressed,
    output logic [kpq_pkg::KEY_W-1:0]        last_pressed_code,
    output logic                             repeat_valid,
    output logic [kpq_pkg::KEY_W-1:0]        repeat_key,
    output logic [kpq_pkg::RCOUNT_W-1:0]     repeat_count,
    output logic [kpq_pkg::TIMER_W-1:0]      repeat_age,
    output logic [kpq_pkg::LEVEL_W-1:0]      events_consumed,
    output logic [kpq_pkg::LEVEL_W-1:0]      queue_level,
    // Configuration port
    input  logic                             cfg_we,
    input  logic [kpq_pkg::THRESH_W-1:0]     cfg_data
);
    import kpq_pkg::*;

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int EV_W  = KEY_ID_BITS + 1;
    localparam int CNT_W = (PTR_W + 1 > LEVEL_W) ? PTR_W + 1 : LEVEL_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_AGE    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    logic [2:0]          state_reg, state_next;
    logic [NUM_KEYS-1:0] keys_reg, keys_next;
    logic [NUM_KEYS-1:0] prev_reg, prev_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic                rtrack_reg, rtrack_next;
    logic [KEY_W-1:0]    rkey_reg, rkey_next;
    logic [RCOUNT_W-1:0] rcount_reg, rcount_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [THRESH_W-1:0] thresh_reg, thresh_next;
    logic [MASK_W-1:0]   change_reg, change_next;
    logic [LEVEL_W-1:0]  consumed_reg, consumed_next;
    logic                acc_reg, acc_next;
    logic                ovf_reg, ovf_next;

    // Latched request payload.
    logic [KEY_ID_W-1:0] req_key_reg, req_key_next;
    logic                req_kind_reg, req_kind_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                o_acc_reg, o_ovf_reg, o_rvalid_reg;
    logic [MASK_W-1:0]   o_down_reg, o_before_reg, o_fresh_reg;
    logic [KEY_W-1:0]    o_code_reg, o_rkey_reg;
    logic [RCOUNT_W-1:0] o_rcount_reg;
    logic [TIMER_W-1:0]  o_age_reg;
    logic [LEVEL_W-1:0]  o_consumed_reg, o_level_reg;

    // ------------------------------------------------------------------
    // Event RAM: entries are {kind, key}. The read port always fetches
    // the entry at the next head, so the head entry is ready every cycle.
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [EV_W-1:0]    ram_wdata;
    logic [EV_W-1:0]    ram_rdata;

    kpq_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared event step unit
    // ------------------------------------------------------------------
    step_in_t  step_in;
    step_out_t step_out;

    always_comb
    begin
        step_in.kind    = ram_rdata[EV_W-1];
        step_in.key     = KEY_W'(ram_rdata[KEY_ID_BITS-1:0]);
        step_in.change  = change_reg;
        step_in.keys    = MASK_W'(keys_reg);
        step_in.tracked = rtrack_reg;
        step_in.rkey    = rkey_reg;
        step_in.rcount  = rcount_reg;
    end

    kpq_step u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------
    logic [PTR_W-1:0] tail_inc, head_inc;
    logic             queue_full, queue_empty, key_ok;
    logic [CNT_W-1:0] level_raw;
    logic [LEVEL_W-1:0] level_sat;

    assign tail_inc    = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
    assign head_inc    = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign queue_full  = (tail_inc == head_reg);
    assign queue_empty = (head_reg == tail_reg);
    assign key_ok      = (req_key_reg < KEY_ID_W'(NUM_KEYS));

    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            level_raw = CNT_W'(tail_reg) - CNT_W'(head_reg);
        end
        else
        begin
            level_raw = CNT_W'(tail_reg) + CNT_W'(QUEUE_DEPTH) - CNT_W'(head_reg);
        end
        level_sat = (level_raw > CNT_W'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(level_raw);
    end

    // Highest newly pressed key; key zero and no key both give code zero.
    logic [MASK_W-1:0] fresh;
    logic [KEY_W-1:0]  fresh_code;

    assign fresh = MASK_W'(keys_reg & ~prev_reg);

    always_comb
    begin
        fresh_code = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (fresh[i])
            begin
                fresh_code = KEY_W'(i);
            end
        end
    end

    assign ram_wdata = {req_kind_reg, req_key_reg[KEY_ID_BITS-1:0]};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        keys_next      = keys_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rtrack_next    = rtrack_reg;
        rkey_next      = rkey_reg;
        rcount_next    = rcount_reg;
        timer_next     = timer_reg;
        change_next    = change_reg;
        consumed_next  = consumed_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        req_key_next   = req_key_reg;
        req_kind_next  = req_kind_reg;
        ram_we         = 1'b0;
        thresh_next    = cfg_we ? cfg_data : thresh_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_key_next  = key_id;
                    req_kind_next = pressed;
                    acc_next      = 1'b0;
                    ovf_next      = 1'b0;
                    consumed_next = '0;
                    change_next   = '0;
                    state_next    = (req_type == REQ_TICK) ? S_AGE : S_ADD;
                end
            end
            S_ADD:
            begin
                // A full queue is flushed before the event is considered.
                if (queue_full)
                begin
                    head_next = tail_reg;
                    ovf_next  = 1'b1;
                end
                if (key_ok)
                begin
                    ram_we    = 1'b1;
                    tail_next = tail_inc;
                    acc_next  = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_AGE:
            begin
                if (timer_reg >= thresh_reg)
                begin
                    rtrack_next = 1'b0;
                    rkey_next   = '0;
                    rcount_next = '0;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                end
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (queue_empty || step_out.stop)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    rtrack_next = step_out.tracked;
                    rkey_next   = step_out.rkey;
                    rcount_next = step_out.rcount;
                    change_next = step_out.change;
                    if (step_out.press)
                    begin
                        timer_next = '0;
                    end
                    head_next = head_inc;
                    if (consumed_reg != LEVEL_MAX)
                    begin
                        consumed_next = consumed_reg + LEVEL_W'(1);
                    end
                end
            end
            S_COMMIT:
            begin
                prev_next  = keys_reg;
                keys_next  = keys_reg ^ change_reg[NUM_KEYS-1:0];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            keys_reg      <= '0;
            prev_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rtrack_reg    <= 1'b0;
            rkey_reg      <= '0;
            rcount_reg    <= '0;
            timer_reg     <= '0;
            thresh_reg    <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keys_reg      <= keys_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rtrack_reg    <= rtrack_next;
            rkey_reg      <= rkey_next;
            rcount_reg    <= rcount_next;
            timer_reg     <= timer_next;
            thresh_reg    <= thresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-item working registers and the result payload need no reset.
    always_ff @(posedge clk)
    begin
        change_reg   <= change_next;
        consumed_reg <= consumed_next;
        acc_reg      <= acc_next;
        ovf_reg      <= ovf_next;
        req_key_reg  <= req_key_next;
        req_kind_reg <= req_kind_next;
        if (out_load)
        begin
            o_acc_reg      <= acc_reg;
            o_ovf_reg      <= ovf_reg;
            o_down_reg     <= MASK_W'(keys_reg);
            o_before_reg   <= MASK_W'(prev_reg);
            o_fresh_reg    <= fresh;
            o_code_reg     <= fresh_code;
            o_rvalid_reg   <= rtrack_reg;
            o_rkey_reg     <= rkey_reg;
            o_rcount_reg   <= rcount_reg;
            o_age_reg      <= timer_reg;
            o_consumed_reg <= consumed_reg;
            o_level_reg    <= level_sat;
        end
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = o_acc_reg;
    assign overflowed        = o_ovf_reg;
    assign keys_down         = o_down_reg;
    assign keys_before       = o_before_reg;
    assign newly_pressed     = o_fresh_reg;
    assign last_pressed_code = o_code_reg;
    assign repeat_valid      = o_rvalid_reg;
    assign repeat_key        = o_rkey_reg;
    assign repeat_count      = o_rcount_reg;
    assign repeat_age        = o_age_reg;
    assign events_consumed   = o_consumed_reg;
    assign queue_level       = o_level_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KPQ_ASSERT(a_count_when_tracked, (rtrack_reg == (rcount_reg != '0)),
        "repeat count and tracking flag disagree")
    `KPQ_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> (state_reg != S_IDLE),
        "sequencer stayed idle after taking an item")
    `KPQ_NEVER(a_add_consumes, (out_valid && accepted && (events_consumed != '0)),
        "an add result reports drained events")
    `KPQ_NEVER(a_queue_overfill, (level_raw > CNT_W'(QUEUE_DEPTH - 1)),
        "queue holds more events than its capacity")

endmodule

FILE: design/kpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kpq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/kpq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad event step unit
// Judges one queued event: stop check, repeat tracking and key change.
// ----------------------------------------------------------------------------
module kpq_step (
    input  kpq_pkg::step_in_t  step_in,
    output kpq_pkg::step_out_t step_out
);
    import kpq_pkg::*;

    logic [MASK_W-1:0] bit_sel;
    logic              same_key;

    assign bit_sel  = MASK_W'(1) << step_in.key;
    assign same_key = step_in.tracked && (step_in.rkey == step_in.key);

    always_comb
    begin
        step_out.stop    = |(step_in.change & bit_sel);
        step_out.press   = step_in.kind;
        step_out.tracked = step_in.tracked;
        step_out.rkey    = step_in.rkey;
        step_out.rcount  = step_in.rcount;
        if (step_in.kind)
        begin
            // A press of a new key starts a fresh candidate.
            if (!same_key)
            begin
                step_out.tracked = 1'b1;
                step_out.rkey    = step_in.key;
                step_out.rcount  = RCOUNT_W'(1);
            end
            else if (step_in.rcount != RCOUNT_MAX)
            begin
                step_out.rcount = step_in.rcount + RCOUNT_W'(1);
            end
        end
        if (step_in.keys[step_in.key] != step_in.kind)
        begin
            step_out.change = step_in.change | bit_sel;
        end
        else
        begin
            step_out.change = step_in.change;
        end
    end

endmodule
